@@ rtl/core/d2p_pkg.sv @@
package d2p_pkg;

	localparam int COL_W = 12;
	localparam int ROW_W = 12;
	localparam int DISP_W = 16;
	localparam int FOCAL_W = 24;
	localparam int CENTER_W = 21;
	localparam int BASE_W = 20;
	localparam int COORD_W = 32;
	localparam int DEPTH_W = 24;
	localparam int COLOR_W = 8;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BASELINE = 3'd4;

	localparam int PROD_W = FOCAL_W + BASE_W;   // focal_x * baseline
	localparam int DEN_D_W = DISP_W + 3;        // 8 * disparity
	localparam int MAG_W = 22;                  // offset from the principal point, Q.8
	localparam int PRODC_W = MAG_W + DEPTH_W;   // offset times depth

	// Pipelined divider: 48-bit dividend, 26-bit divisor, 32 quotient bits.
	localparam int NUM_W = 48;
	localparam int DEN_W = 26;
	localparam int Q_W = 32;
	localparam int DIV_STAGES = Q_W;

	localparam logic [16:0] MIN_DEPTH_UM = 17'd100000;
	localparam logic [23:0] MAX_DEPTH_UM = 24'd10000000;

	// Accept edge to the edge that takes the result.
	localparam int LATENCY = 2 * DIV_STAGES + 5;

	typedef struct packed {
		logic [MAG_W-1:0]   mag_x;
		logic               neg_x;
		logic [MAG_W-1:0]   mag_y;
		logic               neg_y;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} depth_side_t;

	typedef struct packed {
		logic               neg_x;
		logic               sat_x;
		logic               neg_y;
		logic               sat_y;
		logic [DEPTH_W-1:0] depth;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} coord_side_t;

	// Apply the sign to a rounded magnitude and clamp to the signed 32-bit range.
	function automatic logic [COORD_W-1:0] apply_sign(input logic [Q_W-1:0] q,
			input logic neg, input logic sat);
		logic [COORD_W-1:0] res;
		if (neg) begin
			if (sat || q > 32'h8000_0000) begin
				res = 32'h8000_0000;
			end else begin
				res = 32'(~q + 32'd1);
			end
		end else begin
			if (sat || q[Q_W-1]) begin
				res = 32'h7FFF_FFFF;
			end else begin
				res = q;
			end
		end
		return res;
	endfunction

endpackage

@@ rtl/core/d2p_div.sv @@
// Restoring divider, one quotient bit per pipeline stage.
// The dividend must be below divisor * 2^Q_W; otherwise the quotient is meaningless.
module d2p_div
	import d2p_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             out_valid,
	output logic [Q_W-1:0]   quot
);

	logic             vld_s [0:DIV_STAGES];
	logic [DEN_W-1:0] rem_s [0:DIV_STAGES];
	logic [Q_W-1:0]   low_s [0:DIV_STAGES];
	logic [DEN_W-1:0] den_s [0:DIV_STAGES];
	logic [Q_W-1:0]   quo_s [0:DIV_STAGES];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = DEN_W'(num[NUM_W-1:Q_W]);
	assign low_s[0] = num[Q_W-1:0];
	assign den_s[0] = den;
	assign quo_s[0] = '0;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [DEN_W:0] trial;
		logic           take;

		assign trial = {rem_s[k], low_s[k][Q_W-1]};
		assign take = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= take ? DEN_W'(trial - {1'b0, den_s[k]}) : trial[DEN_W-1:0];
			low_s[k+1] <= {low_s[k][Q_W-2:0], 1'b0};
			den_s[k+1] <= den_s[k];
			quo_s[k+1] <= {quo_s[k][Q_W-2:0], take};
		end
	end

	assign out_valid = vld_s[DIV_STAGES];
	assign quot = quo_s[DIV_STAGES];

endmodule

@@ rtl/core/disparity_to_point_reprojection.sv @@
// Stereo disparity to 3-D point reprojection.
// Pixel words enter on the command channel: a word is taken at a rising edge where
// start is high and busy is low. busy stays low, so a pixel may be offered every cycle.
// The camera registers (focal_x, focal_y, center_x, center_y, baseline) are written
// through the cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data); cfg_ready is
// always high and indexes past the register list are ignored. Write them only while
// no pixel is in flight.
// A pixel that passes every check produces one point word: point_valid is high for
// exactly one cycle with point_x, point_y, point_z and the RGB color. Rejected pixels
// produce nothing. Throughput is one pixel per cycle. The pipeline is made of the
// two 32-stage dividers in series (depth, then both coordinates side by side), plus
// five stages for the checks, the multipliers and the output register.
// The receiver cannot stall this block, so there is no back pressure anywhere.
// Reset clears the camera registers to zero (which rejects every pixel) and empties
// the pipeline; any word in flight is lost.
module disparity_to_point_reprojection
	import d2p_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [COL_W-1:0]            pixel_column,
	input  logic [ROW_W-1:0]            pixel_row,
	input  logic [DISP_W-1:0]           disparity_value,
	input  logic                        disparity_valid,
	input  logic [COLOR_W-1:0]          in_blue,
	input  logic [COLOR_W-1:0]          in_green,
	input  logic [COLOR_W-1:0]          in_red,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	output logic                        point_valid,
	output logic signed [COORD_W-1:0]   point_x,
	output logic signed [COORD_W-1:0]   point_y,
	output logic [DEPTH_W-1:0]          point_z,
	output logic [COLOR_W-1:0]          out_red,
	output logic [COLOR_W-1:0]          out_green,
	output logic [COLOR_W-1:0]          out_blue
);

	// Camera registers.
	logic [FOCAL_W-1:0]         focal_x_q;
	logic [FOCAL_W-1:0]         focal_y_q;
	logic signed [CENTER_W-1:0] center_x_q;
	logic signed [CENTER_W-1:0] center_y_q;
	logic [BASE_W-1:0]          baseline_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q <= '0;
			focal_y_q <= '0;
			center_x_q <= '0;
			center_y_q <= '0;
			baseline_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FOCAL_X:  focal_x_q <= cfg_data;
				CFG_FOCAL_Y:  focal_y_q <= cfg_data;
				CFG_CENTER_X: center_x_q <= cfg_data[CENTER_W-1:0];
				CFG_CENTER_Y: center_y_q <= cfg_data[CENTER_W-1:0];
				CFG_BASELINE: baseline_q <= cfg_data[BASE_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1: the cheap checks, focal_x * baseline, and the signed offsets of the pixel
	// from the principal point, split into magnitude and sign.
	logic signed [MAG_W-1:0] off_x;
	logic signed [MAG_W-1:0] off_y;
	logic                    pass_in;

	assign off_x = $signed({2'b00, pixel_column, 8'h00}) - MAG_W'(center_x_q);
	assign off_y = MAG_W'(center_y_q) - $signed({2'b00, pixel_row, 8'h00});
	assign pass_in = (focal_x_q != '0) && (focal_y_q != '0) && (baseline_q != '0)
		&& disparity_valid && (disparity_value != '0)
		&& ({pixel_column, 5'b0} >= {1'b0, disparity_value});

	logic                v_s1;
	logic [PROD_W-1:0]   num_s1;
	logic [DEN_D_W-1:0]  den_s1;
	depth_side_t         side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy && pass_in;
		end
	end

	always_ff @(posedge clk) begin
		num_s1 <= PROD_W'(focal_x_q) * PROD_W'(baseline_q);
		den_s1 <= {disparity_value, 3'b000};
		side_s1.mag_x <= off_x[MAG_W-1] ? MAG_W'(-off_x) : off_x;
		side_s1.neg_x <= off_x[MAG_W-1];
		side_s1.mag_y <= off_y[MAG_W-1] ? MAG_W'(-off_y) : off_y;
		side_s1.neg_y <= off_y[MAG_W-1];
		side_s1.red <= in_red;
		side_s1.green <= in_green;
		side_s1.blue <= in_blue;
	end

	// Stage 2: depth window on the exact quotient, then the rounded depth division
	// (2N + D) / 2D is set up for the divider.
	logic too_near;
	logic too_far;

	assign too_near = num_s1 < PROD_W'(MIN_DEPTH_UM) * PROD_W'(den_s1);
	assign too_far = num_s1 > PROD_W'(MAX_DEPTH_UM) * PROD_W'(den_s1);

	logic             v_s2;
	logic [NUM_W-1:0] dnum_s2;
	logic [DEN_W-1:0] dden_s2;
	depth_side_t      side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && !too_near && !too_far;
		end
	end

	always_ff @(posedge clk) begin
		dnum_s2 <= NUM_W'({num_s1, 1'b0}) + NUM_W'(den_s1);
		dden_s2 <= DEN_W'({den_s1, 1'b0});
		side_s2 <= side_s1;
	end

	logic           zdiv_valid;
	logic [Q_W-1:0] zdiv_quot;

	d2p_div u_zdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.num       (dnum_s2),
		.den       (dden_s2),
		.out_valid (zdiv_valid),
		.quot      (zdiv_quot)
	);

	// Side data rides along the depth divider in a plain delay line.
	depth_side_t zside_q [0:DIV_STAGES-1];

	always_ff @(posedge clk) begin
		zside_q[0] <= side_s2;
		for (int i = 1; i < DIV_STAGES; i++) begin
			zside_q[i] <= zside_q[i-1];
		end
	end

	// Stage 3: offset magnitude times depth for both axes.
	logic               v_s3;
	logic [PRODC_W-1:0] prod_x_s3;
	logic [PRODC_W-1:0] prod_y_s3;
	logic [DEPTH_W-1:0] depth_s3;
	depth_side_t        side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= zdiv_valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_x_s3 <= PRODC_W'(zside_q[DIV_STAGES-1].mag_x) * PRODC_W'(zdiv_quot[DEPTH_W-1:0]);
		prod_y_s3 <= PRODC_W'(zside_q[DIV_STAGES-1].mag_y) * PRODC_W'(zdiv_quot[DEPTH_W-1:0]);
		depth_s3 <= zdiv_quot[DEPTH_W-1:0];
		side_s3 <= zside_q[DIV_STAGES-1];
	end

	// Stage 4: rounded division setup (2P + f) / 2f. A quotient of 2^32 or more shows up
	// as the upper dividend bits reaching the divisor; that word saturates.
	logic [NUM_W-1:0] xnum;
	logic [NUM_W-1:0] ynum;
	logic [DEN_W-1:0] xden;
	logic [DEN_W-1:0] yden;

	assign xnum = NUM_W'({prod_x_s3, 1'b0}) + NUM_W'(focal_x_q);
	assign ynum = NUM_W'({prod_y_s3, 1'b0}) + NUM_W'(focal_y_q);
	assign xden = DEN_W'({focal_x_q, 1'b0});
	assign yden = DEN_W'({focal_y_q, 1'b0});

	logic             v_s4;
	logic [NUM_W-1:0] xnum_s4;
	logic [NUM_W-1:0] ynum_s4;
	logic [DEN_W-1:0] xden_s4;
	logic [DEN_W-1:0] yden_s4;
	coord_side_t      side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		xnum_s4 <= xnum;
		ynum_s4 <= ynum;
		xden_s4 <= xden;
		yden_s4 <= yden;
		side_s4.neg_x <= side_s3.neg_x;
		side_s4.sat_x <= DEN_W'(xnum[NUM_W-1:Q_W]) >= xden;
		side_s4.neg_y <= side_s3.neg_y;
		side_s4.sat_y <= DEN_W'(ynum[NUM_W-1:Q_W]) >= yden;
		side_s4.depth <= depth_s3;
		side_s4.red <= side_s3.red;
		side_s4.green <= side_s3.green;
		side_s4.blue <= side_s3.blue;
	end

	logic           xdiv_valid;
	logic [Q_W-1:0] xdiv_quot;
	logic           ydiv_valid;
	logic [Q_W-1:0] ydiv_quot;

	d2p_div u_xdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.num       (xnum_s4),
		.den       (xden_s4),
		.out_valid (xdiv_valid),
		.quot      (xdiv_quot)
	);

	// Same timing as the X divider; its valid is combined with the X valid for point_valid.
	d2p_div u_ydiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.num       (ynum_s4),
		.den       (yden_s4),
		.out_valid (ydiv_valid),
		.quot      (ydiv_quot)
	);

	coord_side_t cside_q [0:DIV_STAGES-1];

	always_ff @(posedge clk) begin
		cside_q[0] <= side_s4;
		for (int i = 1; i < DIV_STAGES; i++) begin
			cside_q[i] <= cside_q[i-1];
		end
	end

	// Stage 5: sign, saturation and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_valid <= 1'b0;
		end else begin
			point_valid <= xdiv_valid && ydiv_valid;
		end
	end

	always_ff @(posedge clk) begin
		point_x <= apply_sign(xdiv_quot, cside_q[DIV_STAGES-1].neg_x,
			cside_q[DIV_STAGES-1].sat_x);
		point_y <= apply_sign(ydiv_quot, cside_q[DIV_STAGES-1].neg_y,
			cside_q[DIV_STAGES-1].sat_y);
		point_z <= cside_q[DIV_STAGES-1].depth;
		out_red <= cside_q[DIV_STAGES-1].red;
		out_green <= cside_q[DIV_STAGES-1].green;
		out_blue <= cside_q[DIV_STAGES-1].blue;
	end

endmodule

@@ rtl/core/d2p_checker.sv @@
module d2p_checker
	import d2p_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               disparity_valid,
	input logic               point_valid,
	input logic [DEPTH_W-1:0] point_z
);

	// Every emitted depth lies inside the accepted window.
	assert property (@(posedge clk) disable iff (!arst_n)
		point_valid |-> (point_z >= DEPTH_W'(MIN_DEPTH_UM)) && (point_z <= MAX_DEPTH_UM))
		else $error("point depth outside window");

	// A point is always traced back to a pixel taken one latency earlier.
	assert property (@(posedge clk) disable iff (!arst_n)
		point_valid |-> $past(start && !busy, LATENCY))
		else $error("point without a pixel");

	// A pixel with an invalid disparity never produces a point.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !disparity_valid) |-> ##LATENCY !point_valid)
		else $error("point from invalid disparity");

endmodule

bind disparity_to_point_reprojection d2p_checker u_d2p_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.disparity_valid (disparity_valid),
	.point_valid     (point_valid),
	.point_z         (point_z)
);

@@ tb/tb_disparity_to_point_reprojection.sv @@
// Testbench for the disparity to point reprojection block.
// Pixel words go in on the command channel in random bursts. A monitor on the
// rising edge mirrors every camera register write, predicts the point that
// each accepted pixel yields (if any) and compares every point word, field by
// field, with the oldest prediction still waiting.
module tb_disparity_to_point_reprojection;
	import d2p_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PIXELS_PER_PHASE = 110;

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [DEPTH_W-1:0]        z;
		logic [COLOR_W-1:0]        red;
		logic [COLOR_W-1:0]        green;
		logic [COLOR_W-1:0]        blue;
	} point_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [COL_W-1:0]      pixel_column;
	logic [ROW_W-1:0]      pixel_row;
	logic [DISP_W-1:0]     disparity_value;
	logic                  disparity_valid;
	logic [COLOR_W-1:0]    in_blue;
	logic [COLOR_W-1:0]    in_green;
	logic [COLOR_W-1:0]    in_red;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  point_valid;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic [DEPTH_W-1:0]    point_z;
	logic [COLOR_W-1:0]    out_red;
	logic [COLOR_W-1:0]    out_green;
	logic [COLOR_W-1:0]    out_blue;

	// Mirror of the camera registers, updated when a write is taken.
	longint unsigned cam_focal_x, cam_focal_y, cam_baseline;
	longint          cam_center_x, cam_center_y;

	point_t expected_points[$];
	int     error_count;
	int     cycle_count;
	int     burst_left;

	disparity_to_point_reprojection dut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// A generous cap on the whole run; reaching it means something hung.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Offset times depth over focal length, rounded half away from zero, then
	// clamped to the signed 32-bit range.
	function automatic logic [COORD_W-1:0] scale_offset(input longint offset,
			input longint unsigned depth, input longint unsigned focal);
		logic            neg;
		longint unsigned mag;
		longint unsigned q;
		neg = offset < 0;
		mag = neg ? longint'(-offset) : longint'(offset);
		q = (2 * mag * depth + focal) / (2 * focal);
		if (neg) begin
			if (q > 64'h8000_0000)
				q = 64'h8000_0000;
			return COORD_W'(-q);
		end
		if (q > 64'h7FFF_FFFF)
			q = 64'h7FFF_FFFF;
		return COORD_W'(q);
	endfunction

	// Works out the point for one pixel; returns 0 when the pixel is dropped.
	function automatic bit project_pixel(input logic [COL_W-1:0] col,
			input logic [ROW_W-1:0] row, input logic [DISP_W-1:0] disp,
			input logic disp_ok, input logic [COLOR_W-1:0] b, input logic [COLOR_W-1:0] g,
			input logic [COLOR_W-1:0] r, output point_t pt);
		longint unsigned num, den, depth;
		pt = '{default: '0};
		if (cam_focal_x == 0 || cam_focal_y == 0 || cam_baseline == 0)
			return 0;
		if (!disp_ok || disp == 0)
			return 0;
		// The disparity must not reach past the left edge of the image.
		if (32 * longint'(col) < longint'(disp))
			return 0;
		num = cam_focal_x * cam_baseline;
		den = 8 * longint'(disp);
		// The depth window is tested on the exact quotient, before rounding.
		if (num < 100000 * den || num > 10000000 * den)
			return 0;
		depth = (2 * num + den) / (2 * den);
		pt.x = scale_offset(256 * longint'(col) - cam_center_x, depth, cam_focal_x);
		pt.y = scale_offset(cam_center_y - 256 * longint'(row), depth, cam_focal_y);
		pt.z = DEPTH_W'(depth);
		pt.red = r;
		pt.green = g;
		pt.blue = b;
		return 1;
	endfunction

	// Everything is sampled on the rising edge, before the block updates.
	always @(posedge clk) begin
		point_t pt;
		point_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FOCAL_X: cam_focal_x = cfg_data;
					CFG_FOCAL_Y: cam_focal_y = cfg_data;
					CFG_CENTER_X: cam_center_x = longint'($signed(cfg_data[CENTER_W-1:0]));
					CFG_CENTER_Y: cam_center_y = longint'($signed(cfg_data[CENTER_W-1:0]));
					CFG_BASELINE: cam_baseline = cfg_data[BASE_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (project_pixel(pixel_column, pixel_row, disparity_value, disparity_valid,
						in_blue, in_green, in_red, pt))
					expected_points.push_back(pt);
			end
			if (point_valid) begin
				if (expected_points.size() == 0) begin
					$error("point word with no point expected");
					error_count++;
				end else begin
					want = expected_points.pop_front();
					if (point_x !== want.x) begin
						$error("point_x expected %0d got %0d", want.x, point_x);
						error_count++;
					end
					if (point_y !== want.y) begin
						$error("point_y expected %0d got %0d", want.y, point_y);
						error_count++;
					end
					if (point_z !== want.z) begin
						$error("point_z expected %0d got %0d", want.z, point_z);
						error_count++;
					end
					if (out_red !== want.red) begin
						$error("out_red expected %0d got %0d", want.red, out_red);
						error_count++;
					end
					if (out_green !== want.green) begin
						$error("out_green expected %0d got %0d", want.green, out_green);
						error_count++;
					end
					if (out_blue !== want.blue) begin
						$error("out_blue expected %0d got %0d", want.blue, out_blue);
						error_count++;
					end
				end
			end
		end
	end

	// Offers one pixel word and returns at the edge that takes it. Words come
	// in bursts; between most bursts start drops for a random gap.
	task automatic send_pixel(input int col, input int row, input int disp, input bit ok,
			input int b, input int g, input int r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				start <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		start <= 1'b1;
		pixel_column <= COL_W'(col);
		pixel_row <= ROW_W'(row);
		disparity_value <= DISP_W'(disp);
		disparity_valid <= ok;
		in_blue <= COLOR_W'(b);
		in_green <= COLOR_W'(g);
		in_red <= COLOR_W'(r);
		while (busy) @(negedge clk);
		@(posedge clk);
	endtask

	// Waits until every expected point is out, then lets the pipeline empty,
	// since the last pixels may have been dropped inside it.
	task automatic drain_pipeline();
		@(negedge clk);
		start <= 1'b0;
		burst_left = 0;
		while (expected_points.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
	endtask

	// Writes all five camera registers, plus an ignored write past the list.
	task automatic set_camera(input int fx, input int fy, input int cx, input int cy,
			input int bl);
		write_reg(CFG_FOCAL_X, CFG_DATA_W'(fx));
		write_reg(CFG_FOCAL_Y, CFG_DATA_W'(fy));
		write_reg(CFG_CENTER_X, CFG_DATA_W'(cx));
		write_reg(CFG_CENTER_Y, CFG_DATA_W'(cy));
		write_reg(CFG_BASELINE, CFG_DATA_W'(bl));
		write_reg(CFG_IDX_W'(int'(CFG_BASELINE) + int'($urandom_range(1, 3))),
			CFG_DATA_W'($urandom));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random pixels for the current camera. Most have a disparity inside the
	// depth window and a column that keeps it inside the image; the rest are noise.
	task automatic random_pixels(input int count);
		longint unsigned num;
		int lo, hi, disp, col;
		num = cam_focal_x * cam_baseline;
		lo = int'(num / 80000000) + 1;
		hi = ((num / 800000) > 65535) ? 65535 : int'(num / 800000);
		if (lo > 65535)
			lo = 65535;
		if (hi < lo)
			hi = lo;
		repeat (count) begin
			if ($urandom_range(0, 99) < 85) begin
				disp = $urandom_range(lo, hi);
				col = $urandom_range((disp + 31) / 32, 4095);
				send_pixel(col, $urandom_range(0, 4095), disp, 1'b1,
					$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
			end else begin
				send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 65535), $urandom_range(0, 1),
					$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
			end
		end
	endtask

	// Straight out of reset every register is zero, so nothing may come out.
	task automatic test_unconfigured();
		send_pixel(100, 100, 320, 1'b1, 1, 2, 3);
		send_pixel(4095, 4095, 65535, 1'b1, 255, 255, 255);
		drain_pipeline();
		// A camera with only baseline zero still rejects everything.
		set_camera(153600, 153600, 640 * 256, 360 * 256, 0);
		send_pixel(500, 200, 640, 1'b1, 9, 8, 7);
		drain_pipeline();
	endtask

	// A typical camera: each check that drops a pixel, and the field extremes.
	task automatic test_rejects_and_extremes();
		set_camera(153600, 153600, 640 * 256, 360 * 256, 50000);
		send_pixel(500, 200, 640, 1'b0, 1, 2, 3);       // disparity flagged invalid
		send_pixel(500, 200, 0, 1'b1, 1, 2, 3);         // zero disparity
		send_pixel(10, 200, 321, 1'b1, 1, 2, 3);        // reaches past the left edge
		send_pixel(10, 200, 320, 1'b1, 4, 5, 6);        // exactly on the edge
		send_pixel(500, 200, 95, 1'b1, 1, 2, 3);        // farther than 10 m
		send_pixel(500, 200, 96, 1'b1, 1, 2, 3);        // right at 10 m
		send_pixel(3000, 200, 9601, 1'b1, 1, 2, 3);     // nearer than 0.1 m
		send_pixel(3000, 200, 9600, 1'b1, 1, 2, 3);     // right at 0.1 m
		send_pixel(0, 0, 1, 1'b1, 0, 0, 0);             // column zero, any disparity drops
		send_pixel(4095, 4095, 65535, 1'b1, 255, 255, 255);
		send_pixel(4095, 0, 200, 1'b1, 0, 255, 0);
		send_pixel(0, 4095, 0, 1'b1, 255, 0, 255);
		send_pixel(640, 360, 320, 1'b1, 170, 85, 170);  // on the principal point
		send_pixel(2048, 2048, 33, 1'b1, 85, 170, 85);
		drain_pipeline();
	endtask

	// Tiny focal lengths and extreme centers drive most coordinates into saturation.
	task automatic test_saturation();
		set_camera(256, 256, -1048576, 1048575, 1000000);
		send_pixel(4095, 0, 4, 1'b1, 1, 2, 3);
		send_pixel(100, 0, 100, 1'b1, 4, 5, 6);
		drain_pipeline();
		set_camera(256, 256, 1048575, -1048576, 1000000);
		send_pixel(1, 4095, 8, 1'b1, 7, 8, 9);
		send_pixel(1, 4095, 32, 1'b1, 10, 11, 12);
		drain_pipeline();
		// Largest registers: every depth is far past the window.
		set_camera(16777215, 16777215, 1048575, -1048576, 1048575);
		send_pixel(4095, 4095, 65535, 1'b1, 1, 1, 1);
		drain_pipeline();
		// Smallest nonzero registers: every depth is too near.
		set_camera(1, 1, 0, 0, 1);
		send_pixel(4095, 4095, 1, 1'b1, 1, 1, 1);
		drain_pipeline();
	endtask

	// Random pixels under a sequence of random cameras.
	task automatic test_random_cameras();
		repeat (5) begin
			set_camera($urandom_range(64, 1 << 20), $urandom_range(1, (1 << 24) - 1),
				($urandom_range(0, 7) << 21) | $urandom_range(0, (1 << 21) - 1),
				($urandom_range(0, 7) << 21) | $urandom_range(0, (1 << 21) - 1),
				($urandom_range(0, 15) << 20) | $urandom_range(1000, (1 << 20) - 1));
			random_pixels(PIXELS_PER_PHASE);
			drain_pipeline();
		end
	endtask

	initial begin
		error_count = 0;
		cycle_count = 0;
		burst_left = 0;
		cam_focal_x = 0;
		cam_focal_y = 0;
		cam_center_x = 0;
		cam_center_y = 0;
		cam_baseline = 0;
		arst_n = 1'b0;
		start = 1'b0;
		pixel_column = '0;
		pixel_row = '0;
		disparity_value = '0;
		disparity_valid = 1'b0;
		in_blue = '0;
		in_green = '0;
		in_red = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		test_unconfigured();
		test_rejects_and_extremes();
		test_saturation();
		test_random_cameras();
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/d2p_pkg.sv
rtl/core/d2p_div.sv
rtl/core/disparity_to_point_reprojection.sv
rtl/core/d2p_checker.sv
tb/tb_disparity_to_point_reprojection.sv
